FILE: rtl/core/m4inv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package m4inv_pkg;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MUL,
    S_WAIT_MUL,
    S_DIV,
    S_WAIT_DIV,
    S_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_FETCH_X,
    M_FETCH_Y,
    M_RUN,
    M_ACC
  } mul_state_t;

  // operand codes: 0..15 matrix elements, then the upper-row minors, then the lower-row minors
  localparam logic [4:0] CODE_S_BASE = 5'd16;
  localparam logic [4:0] CODE_C_BASE = 5'd22;

  // destinations 0..11 are the minor registers
  localparam logic [3:0] DEST_DET = 4'd12;
  localparam logic [3:0] DEST_ADJ = 4'd13;

  localparam logic [4:0] STEP_DET_FIRST = 5'd24;
  localparam logic [4:0] STEP_DET_LAST  = 5'd29;

  typedef struct packed {
    logic [4:0] xsel;
    logic [4:0] ysel;
    logic       neg;
    logic       first;
    logic       last;
    logic [3:0] dest;
  } op_t;

  typedef struct packed {
    logic       load;
    logic [3:0] load_index;
    logic       mul_start;
    op_t        op;
    logic       div_start;
    logic       out_load;
    logic [3:0] out_index;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic det_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/m4inv_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module m4inv_dpath #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire m4inv_pkg::cmd_t   cmd,
  input  wire logic [W-1:0]      in_value,
  output m4inv_pkg::status_t     st,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [W-1:0]           out_value,
  output logic [3:0]             out_index,
  output logic                   out_singular,
  output logic                   out_saturated,
  output logic                   out_last
);

  localparam int OW  = 2 * W + 1;
  localparam int AW  = 4 * W + 5;
  localparam int BW  = 3 * W + 3;
  localparam int NB  = BW + 2 * F;
  localparam int MCW = $clog2(OW);
  localparam int DCW = $clog2(NB + 1);

  logic [W-1:0]  mat [16];
  logic [W-1:0]  rd_q;
  logic [3:0]    rd_addr;
  logic [OW-1:0] minor [12];

  m4inv_pkg::mul_state_t mstate;
  m4inv_pkg::op_t        op;
  logic [OW-1:0] mc;
  logic          pneg;
  logic [OW-1:0] hi;
  logic [OW-1:0] lo;
  logic [MCW-1:0] mcnt;
  logic [AW-1:0] acc;
  logic [AW-1:0] det;
  logic [BW-1:0] bval;

  logic           div_busy;
  logic [DCW-1:0] dcnt;
  logic [AW-1:0]  rem;
  logic [NB-1:0]  nq;
  logic           qneg;
  logic [AW-1:0]  den;

  logic [4:0]      cur_code;
  logic [OW-1:0]   opnd;
  logic [OW-1:0]   opnd_mag;
  logic [OW:0]     sum;
  logic [AW-1:0]   term;
  logic [AW-1:0]   sterm;
  logic [AW-1:0]   acc_next;
  logic [AW-1:0]   det_abs;
  logic [BW-1:0]   bmag;
  logic [AW:0]     r2;
  logic [AW:0]     diff;
  logic            ge;
  logic [NB-1:0]   half;
  logic [NB-1:0]   lim;
  logic            over;
  logic [W-1:0]    mag_w;
  logic [W-1:0]    val;
  logic            det_zero;

  always_comb begin
    cur_code = (mstate == m4inv_pkg::M_FETCH_X) ? op.xsel : op.ysel;
    opnd     = cur_code[4] ? minor[cur_code[3:0]] : {{(OW-W){rd_q[W-1]}}, rd_q};
    opnd_mag = opnd[OW-1] ? (~opnd + OW'(1)) : opnd;
    rd_addr  = (mstate == m4inv_pkg::M_IDLE) ? cmd.op.xsel[3:0] : op.ysel[3:0];
    sum      = {1'b0, hi} + (lo[0] ? {1'b0, mc} : {(OW+1){1'b0}});
    term     = AW'({hi, lo});
    sterm    = (pneg ^ op.neg) ? (~term + AW'(1)) : term;
    acc_next = (op.first ? {AW{1'b0}} : acc) + sterm;
    det_zero = (det == {AW{1'b0}});
    det_abs  = det[AW-1] ? (~det + AW'(1)) : det;
    bmag     = bval[BW-1] ? (~bval + BW'(1)) : bval;
    r2       = {rem, nq[NB-1]};
    diff     = r2 - {1'b0, den};
    ge       = (r2 >= {1'b0, den});
    half     = NB'(1) << (W - 1);
    lim      = qneg ? half : (half - NB'(1));
    over     = (nq > lim);
    mag_w    = over ? lim[W-1:0] : nq[W-1:0];
    val      = qneg ? (~mag_w + W'(1)) : mag_w;
  end

  assign st.mul_done = (mstate == m4inv_pkg::M_ACC);
  assign st.div_done = div_busy && (dcnt == DCW'(NB - 1));
  assign st.det_zero = det_zero;
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mat[cmd.load_index] <= in_value;
    end
    rd_q <= mat[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= m4inv_pkg::M_IDLE;
    end else begin
      unique case (mstate)
        m4inv_pkg::M_IDLE: begin
          if (cmd.mul_start) begin
            op     <= cmd.op;
            mstate <= m4inv_pkg::M_FETCH_X;
          end
        end
        m4inv_pkg::M_FETCH_X: begin
          mc     <= opnd_mag;
          pneg   <= opnd[OW-1];
          mstate <= m4inv_pkg::M_FETCH_Y;
        end
        m4inv_pkg::M_FETCH_Y: begin
          lo     <= opnd_mag;
          pneg   <= pneg ^ opnd[OW-1];
          hi     <= '0;
          mcnt   <= '0;
          mstate <= m4inv_pkg::M_RUN;
        end
        m4inv_pkg::M_RUN: begin
          hi   <= sum[OW:1];
          lo   <= {sum[0], lo[OW-1:1]};
          mcnt <= mcnt + MCW'(1);
          if (mcnt == MCW'(OW - 1)) begin
            mstate <= m4inv_pkg::M_ACC;
          end
        end
        m4inv_pkg::M_ACC: begin
          acc <= acc_next;
          if (op.last) begin
            if (op.dest == m4inv_pkg::DEST_DET) begin
              det <= acc_next;
            end else if (op.dest == m4inv_pkg::DEST_ADJ) begin
              bval <= acc_next[BW-1:0];
            end else begin
              minor[op.dest] <= acc_next[OW-1:0];
            end
          end
          mstate <= m4inv_pkg::M_IDLE;
        end
        default: mstate <= m4inv_pkg::M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      den      <= det_abs;
      nq       <= {bmag, {(2*F){1'b0}}};
      rem      <= '0;
      qneg     <= bval[BW-1] ^ det[AW-1];
      dcnt     <= '0;
      div_busy <= 1'b1;
    end else if (div_busy) begin
      rem  <= ge ? diff[AW-1:0] : r2[AW-1:0];
      nq   <= {nq[NB-2:0], ge};
      dcnt <= dcnt + DCW'(1);
      if (dcnt == DCW'(NB - 1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid     <= 1'b1;
      out_value     <= det_zero ? {W{1'b0}} : val;
      out_index     <= cmd.out_index;
      out_singular  <= det_zero;
      out_saturated <= !det_zero && over;
      out_last      <= &cmd.out_index;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/m4inv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module m4inv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire m4inv_pkg::status_t st,
  output m4inv_pkg::cmd_t         cmd
);

  m4inv_pkg::ctrl_state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [4:0] step, step_next;
  logic       adj, adj_next;
  logic [3:0] ent, ent_next;
  logic [1:0] trm, trm_next;

  function automatic m4inv_pkg::op_t decode(input logic adj_phase, input logic [4:0] stp,
                                            input logic [3:0] e, input logic [1:0] t);
    m4inv_pkg::op_t o;
    logic [3:0] m;
    logic [3:0] p;
    logic [1:0] ca;
    logic [1:0] cb;
    logic [1:0] r0;
    logic [1:0] r1;
    logic [2:0] d;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] col;
    logic [3:0] mi;
    o = '0;
    m = stp[4:1];
    p = (m < 4'd6) ? m : (m - 4'd6);
    r0 = (m < 4'd6) ? 2'd0 : 2'd2;
    r1 = r0 | 2'd1;
    d = 3'(stp - m4inv_pkg::STEP_DET_FIRST);
    i = e[3:2];
    j = e[1:0];
    col = (t < i) ? t : (t + 2'd1);
    unique case (p)
      4'd0: begin ca = 2'd0; cb = 2'd1; end
      4'd1: begin ca = 2'd0; cb = 2'd2; end
      4'd2: begin ca = 2'd0; cb = 2'd3; end
      4'd3: begin ca = 2'd1; cb = 2'd2; end
      4'd4: begin ca = 2'd1; cb = 2'd3; end
      default: begin ca = 2'd2; cb = 2'd3; end
    endcase
    unique case ({i, t})
      4'b00_00: mi = 4'd5;
      4'b00_01: mi = 4'd4;
      4'b00_10: mi = 4'd3;
      4'b01_00: mi = 4'd5;
      4'b01_01: mi = 4'd2;
      4'b01_10: mi = 4'd1;
      4'b10_00: mi = 4'd4;
      4'b10_01: mi = 4'd2;
      4'b10_10: mi = 4'd0;
      4'b11_00: mi = 4'd3;
      4'b11_01: mi = 4'd1;
      default:  mi = 4'd0;
    endcase
    if (adj_phase) begin
      o.xsel  = {1'b0, j[1], ~j[0], col};
      o.ysel  = (j[1] ? m4inv_pkg::CODE_S_BASE : m4inv_pkg::CODE_C_BASE) + {1'b0, mi};
      o.neg   = i[0] ^ j[0] ^ t[0];
      o.first = (t == 2'd0);
      o.last  = (t == 2'd2);
      o.dest  = m4inv_pkg::DEST_ADJ;
    end else if (stp < m4inv_pkg::STEP_DET_FIRST) begin
      o.xsel  = stp[0] ? {1'b0, r1, ca} : {1'b0, r0, ca};
      o.ysel  = stp[0] ? {1'b0, r0, cb} : {1'b0, r1, cb};
      o.neg   = stp[0];
      o.first = !stp[0];
      o.last  = stp[0];
      o.dest  = m;
    end else begin
      o.xsel  = m4inv_pkg::CODE_S_BASE + {2'b0, d};
      o.ysel  = m4inv_pkg::CODE_C_BASE + 5'd5 - {2'b0, d};
      o.neg   = (d == 3'd1) || (d == 3'd4);
      o.first = (stp == m4inv_pkg::STEP_DET_FIRST);
      o.last  = (stp == m4inv_pkg::STEP_DET_LAST);
      o.dest  = m4inv_pkg::DEST_DET;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4inv_pkg::S_LOAD;
      cnt   <= '0;
      step  <= '0;
      adj   <= 1'b0;
      ent   <= '0;
      trm   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      step  <= step_next;
      adj   <= adj_next;
      ent   <= ent_next;
      trm   <= trm_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    adj_next   = adj;
    ent_next   = ent;
    trm_next   = trm;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = decode(adj, step, ent, trm);
    cmd.load_index = cnt;
    cmd.out_index  = ent;
    unique case (state)
      m4inv_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = cnt + 4'd1;
          if (&cnt) begin
            step_next  = '0;
            adj_next   = 1'b0;
            ent_next   = '0;
            trm_next   = '0;
            state_next = m4inv_pkg::S_MUL;
          end
        end
      end
      m4inv_pkg::S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = m4inv_pkg::S_WAIT_MUL;
      end
      m4inv_pkg::S_WAIT_MUL: begin
        if (st.mul_done) begin
          if (adj) begin
            if (trm == 2'd2) begin
              state_next = st.det_zero ? m4inv_pkg::S_OUT : m4inv_pkg::S_DIV;
            end else begin
              trm_next   = trm + 2'd1;
              state_next = m4inv_pkg::S_MUL;
            end
          end else begin
            if (step == m4inv_pkg::STEP_DET_LAST) begin
              adj_next = 1'b1;
              trm_next = '0;
            end else begin
              step_next = step + 5'd1;
            end
            state_next = m4inv_pkg::S_MUL;
          end
        end
      end
      m4inv_pkg::S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = m4inv_pkg::S_WAIT_DIV;
      end
      m4inv_pkg::S_WAIT_DIV: begin
        if (st.div_done) begin
          state_next = m4inv_pkg::S_OUT;
        end
      end
      m4inv_pkg::S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          trm_next     = '0;
          ent_next     = ent + 4'd1;
          state_next   = (&ent) ? m4inv_pkg::S_LOAD : m4inv_pkg::S_MUL;
        end
      end
      default: state_next = m4inv_pkg::S_LOAD;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/matrix4_inverse_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  tdata (low bit up)                     tuser / tlast
// s_axis    in   element_value                          -
// m_axis    out  inverse_value, element_index           singular, saturated / last
//
// Elements load at one per cycle. The matrix is then solved on one shared shift-add
// multiplier: 78 products in all, 30 for the minors and the determinant and three per
// result, and per result one restoring divide (skipped when singular) before the result
// is handed over. New elements are taken once the last result is loaded.
// A stalled output holds the unit before its next result. Reset is synchronous.
module matrix4_inverse_unit #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  input  wire logic [((WORD_BITS+7)/8)*8-1:0]         s_tdata,  // element_value
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [((WORD_BITS+4+7)/8)*8-1:0]            m_tdata,  // inverse_value, element_index
  output logic [1:0]                                  m_tuser,  // singular, saturated
  output logic                                        m_tlast
);

  localparam int M_BITS = ((WORD_BITS + 4 + 7) / 8) * 8;

  m4inv_pkg::cmd_t    cmd;
  m4inv_pkg::status_t st;
  logic [WORD_BITS-1:0] out_value;
  logic [3:0]           out_index;
  logic                 out_singular;
  logic                 out_saturated;

  m4inv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  m4inv_dpath #(
    .W (WORD_BITS),
    .F (FRACTION_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_value      (s_tdata[WORD_BITS-1:0]),
    .st            (st),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_value     (out_value),
    .out_index     (out_index),
    .out_singular  (out_singular),
    .out_saturated (out_saturated),
    .out_last      (m_tlast)
  );

  assign m_tdata = M_BITS'({out_index, out_value});
  assign m_tuser = {out_saturated, out_singular};

endmodule
`default_nettype wire

FILE: test/matrix4_inverse_checker.sv
`timescale 1ns / 1ps
module matrix4_inverse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  index;
    logic        singular;
    logic        saturated;
    logic        last;
  } inv_elem_t;

  logic signed [31:0] matrix[16];
  int                 fill;
  inv_elem_t          inverse_q[$];

  function automatic wide_t cofactor(input logic signed [31:0] m[16], input int r, input int c);
    int    rows[3];
    int    cols[3];
    int    n;
    wide_t e[3][3];
    wide_t sum;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin rows[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin cols[n] = k; n++; end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        e[a][b] = wide_t'(m[rows[a] * 4 + cols[b]]);
    sum = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
        - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
        + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    return ((r + c) % 2 == 1) ? -sum : sum;
  endfunction

  task automatic solve_matrix();
    wide_t     det;
    wide_t     q;
    inv_elem_t x;
    det = '0;
    for (int c = 0; c < 4; c++) det += wide_t'(matrix[c]) * cofactor(matrix, 0, c);
    for (int k = 0; k < 16; k++) begin
      x.index = k[3:0];
      x.last = (k == 15);
      x.singular = (det == 0);
      x.saturated = 1'b0;
      x.value = '0;
      if (det != 0) begin
        q = (cofactor(matrix, k % 4, k / 4) * (wide_t'(1) <<< 32)) / det;
        if (q > wide_t'(32'sh7fffffff)) begin
          q = wide_t'(32'sh7fffffff);
          x.saturated = 1'b1;
        end else if (q < wide_t'(-64'sd2147483648)) begin
          q = wide_t'(-64'sd2147483648);
          x.saturated = 1'b1;
        end
        x.value = q[31:0];
      end
      inverse_q.push_back(x);
    end
  endtask

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%t %s", $realtime, what);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    fill = 0;
  end

  always @(posedge clk) begin
    inv_elem_t x;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        matrix[fill] = s_tdata;
        if (fill == 15) begin
          fill = 0;
          solve_matrix();
        end else fill++;
      end
      if (m_tvalid && m_tready) begin
        if (inverse_q.size() == 0) begin
          report($sformatf("unexpected transfer tdata=%h tuser=%b tlast=%b",
                           m_tdata, m_tuser, m_tlast));
        end else begin
          x = inverse_q.pop_front();
          if (m_tdata[31:0] !== x.value || m_tdata[35:32] !== x.index ||
              m_tuser[0] !== x.singular || m_tuser[1] !== x.saturated ||
              m_tlast !== x.last)
            report($sformatf("exp val=%h idx=%0d sing/sat/last=%b%b%b, %s",
                             x.value, x.index, x.singular, x.saturated, x.last,
                             $sformatf("got val=%h idx=%0d sing/sat/last=%b%b%b",
                                       m_tdata[31:0], m_tdata[35:32], m_tuser[0],
                                       m_tuser[1], m_tlast)));
        end
      end
      pending = inverse_q.size() + (fill != 0);
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix4_inverse_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  matrix4_inverse_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_element(input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_matrix(input logic [31:0] m[16]);
    for (int k = 0; k < 16; k++) send_element(m[k]);
  endtask

  initial begin
    logic [31:0] m[16];
    int          kind;
    int          src;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // singular, with the field extremes
    m = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1,
          32'hffffffff, 32'h00010000, 32'h80000000, 32'h7fffffff,
          32'h0, 32'h0, 32'h0, 32'h0,
          32'h12345678, 32'hedcba987, 32'h55555555, 32'haaaaaaaa};
    send_matrix(m);
    // diagonal: positive and negative clipping, exact minimum, plain value
    m = '{default: 32'h0};
    m[0] = 32'h1;
    m[5] = 32'hffffffff;
    m[10] = 32'hfffffffe;
    m[15] = 32'h7fffffff;
    send_matrix(m);

    for (int n = 0; n < 17; n++) begin
      case (n % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      kind = $urandom_range(3);
      for (int k = 0; k < 16; k++) begin
        case (kind)
          0: m[k] = $urandom;
          1: m[k] = $urandom_range(262143) - 131072;
          2: m[k] = (k % 5 == 0) ? 32'h10000 + $urandom_range(4095) - 2048
                                 : $urandom_range(511) - 256;
          default: m[k] = $urandom_range(65535) - 32768;
        endcase
      end
      if (kind == 3) begin
        // two equal rows make it singular
        src = $urandom_range(3);
        for (int c = 0; c < 4; c++) m[((src + 1) % 4) * 4 + c] = m[src * 4 + c];
      end
      send_matrix(m);
    end
    s_tvalid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("matrix4_inverse_unit: match");
    else $display("matrix4_inverse_unit: mismatch");
    $finish;
  end

  initial begin
    #12ms;
    $display("matrix4_inverse_unit: mismatch");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/m4inv_pkg.sv
rtl/core/m4inv_dpath.sv
rtl/core/m4inv_ctrl.sv
rtl/core/matrix4_inverse_unit.sv
test/matrix4_inverse_checker.sv
test/testbench.sv
